// ===== rtl/nfba_pkg.sv =====
package nfba_pkg;

    localparam int OP_W = 2;
    localparam int VAL_W = 17;
    localparam int ADDR_W = 16;
    localparam int MIN_FLOOR = 32;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_FIND  = 2'd2,
        OP_SIZE  = 2'd3
    } op_t;

    localparam logic REG_POOL = 1'b0;
    localparam logic REG_MIN  = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_SPLIT_POP,
        ST_SPLIT_WAIT,
        ST_SPLIT_NEW,
        ST_SPLIT_NEXT,
        ST_ALLOC_DONE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_FREE_PREV_RD,
        ST_FREE_PREV_CHK,
        ST_FREE_NEXT_RD,
        ST_FREE_NEXT_CHK,
        ST_MERGE_NN_RD,
        ST_MERGE_NN_CHK,
        ST_PUSH,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic        used;
        logic [16:0] size;
        logic [15:0] start;
    } desc_base_t;

endpackage

// ===== rtl/next_fit_block_allocator_top.sv =====
// Block allocator over a byte pool kept as an address-ordered linked list of
// descriptors held in on-chip memories. One request is in flight at a time and
// gives one result. Alloc walks the list next-fit from the roving descriptor,
// with a memory read then a check for each descriptor visited, then either
// splits the block (pop a spare, write the new tail, relink) or gives it whole,
// and returns the result. Find, free and get size walk from the first
// descriptor in the same way, and free then merges neighbours and returns spare
// descriptors. After reset and after every configuration write the block runs a
// clearing pass that rebuilds the spare descriptor stack and the pool; no
// request is accepted during that pass.
module next_fit_block_allocator_top
    import nfba_pkg::*;
#(
    parameter int MAX_BLOCKS = 2049,
    parameter int HEADER_BYTES = 8,
    parameter int POOL_BYTES_MAX = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], amount[18:2], address[34:19], zero fill
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], value[17:1], zero fill
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int IW = $clog2(MAX_BLOCKS + 1);
    localparam logic [IW-1:0] NIL = IW'(MAX_BLOCKS);
    localparam logic [IW-1:0] SPARE_FULL = IW'(MAX_BLOCKS - 1);
    localparam logic [16:0] HDR = 17'(HEADER_BYTES);
    localparam logic [16:0] PMAX = (POOL_BYTES_MAX > 65536) ? 17'd65536 : 17'(POOL_BYTES_MAX);

    desc_base_t    base_mem [MAX_BLOCKS];
    logic [IW-1:0] prev_mem [MAX_BLOCKS];
    logic [IW-1:0] next_mem [MAX_BLOCKS];
    logic [IW-1:0] spare_mem [MAX_BLOCKS];

    state_t        state_reg, state_next;
    logic [16:0]   pool_reg, minb_reg;
    logic [IW-1:0] spare_cnt_reg, rov_reg;
    logic [16:0]   inuse_reg;
    logic [IW-1:0] clr_reg;
    op_t           op_reg;
    logic [16:0]   need_reg;
    logic [15:0]   addr_reg;
    logic [IW-1:0] cur_reg, aux_reg, nb_reg, steps_reg;
    logic          split_reg;
    logic [16:0]   fsize_reg;
    logic          fail_reg;
    logic [16:0]   val_reg;
    logic          mv_reg;
    logic [23:0]   md_reg;

    // memory ports: one read address for descriptors, one for spare stack
    logic [IW-1:0] rd_addr;
    desc_base_t    rd_base;
    logic [IW-1:0] rd_prev, rd_next;
    logic [IW-1:0] sp_rd_addr, sp_rd;
    logic          bw_en, pw_en, nw_en, sw_en;
    logic [IW-1:0] bw_addr, pw_addr, nw_addr, sw_addr;
    desc_base_t    bw_data;
    logic [IW-1:0] pw_data, nw_data, sw_data;

    always_ff @(posedge aclk) begin
        if (bw_en) base_mem[bw_addr] <= bw_data;
        if (pw_en) prev_mem[pw_addr] <= pw_data;
        if (nw_en) next_mem[nw_addr] <= nw_data;
        if (sw_en) spare_mem[sw_addr] <= sw_data;
        rd_base <= base_mem[rd_addr];
        rd_prev <= prev_mem[rd_addr];
        rd_next <= next_mem[rd_addr];
        sp_rd <= spare_mem[sp_rd_addr];
    end

    // input unpacking
    op_t         in_op;
    logic [16:0] in_amt;
    logic [15:0] in_addr;
    logic [17:0] in_need;
    assign in_op = op_t'(s_tdata[1:0]);
    assign in_amt = s_tdata[18:2];
    assign in_addr = s_tdata[34:19];
    assign in_need = 18'(in_amt) + 18'(HDR);

    logic s_fire, cfg_fire, out_free;
    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign s_fire = s_tvalid && s_tready;
    assign cfg_fire = cfg_valid && cfg_ready;

    assign m_tvalid = mv_reg;
    assign m_tdata = md_reg;

    // derived values from registered read
    logic [16:0] rd_end;
    logic [16:0] haddr;
    logic        addr_lo;
    logic [IW-1:0] nof;
    assign rd_end = 17'(rd_base.start) + rd_base.size;
    assign addr_lo = (17'(addr_reg) < HDR);
    assign haddr = 17'(addr_reg) - HDR;
    assign nof = (rd_next != NIL) ? rd_next : '0;

    logic walk_hit;
    always_comb begin
        if (op_reg == OP_FIND)
            walk_hit = rd_base.used && (rd_base.start <= addr_reg)
                && (17'(addr_reg) < rd_end);
        else
            walk_hit = rd_base.used && !addr_lo && (17'(rd_base.start) == haddr);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:        if (clr_reg == SPARE_FULL) state_next = ST_IDLE;
            ST_IDLE: begin
                if (cfg_fire) state_next = ST_CLEAR;
                else if (s_fire) begin
                    if (in_op == OP_ALLOC) state_next = ST_ALLOC_RD;
                    else state_next = ST_WALK_RD;
                end
            end
            ST_ALLOC_RD:     state_next = ST_ALLOC_CHK;
            ST_ALLOC_CHK: begin
                if (fail_reg) state_next = ST_RESULT;
                else if (!rd_base.used && rd_base.size >= need_reg) begin
                    if (need_reg < rd_base.size && spare_cnt_reg != '0)
                        state_next = ST_SPLIT_POP;
                    else state_next = ST_ALLOC_DONE;
                end else if (nof == rov_reg || steps_reg == SPARE_FULL)
                    state_next = ST_RESULT;
                else state_next = ST_ALLOC_RD;
            end
            ST_SPLIT_POP:    state_next = ST_SPLIT_WAIT;
            ST_SPLIT_WAIT:   state_next = ST_SPLIT_NEW;
            ST_SPLIT_NEW:    state_next = ST_SPLIT_NEXT;
            ST_SPLIT_NEXT:   state_next = ST_ALLOC_DONE;
            ST_ALLOC_DONE:   state_next = ST_RESULT;
            ST_WALK_RD:      state_next = (fail_reg) ? ST_RESULT : ST_WALK_CHK;
            ST_WALK_CHK: begin
                if (walk_hit) begin
                    if (op_reg == OP_FREE) state_next = ST_FREE_PREV_RD;
                    else state_next = ST_RESULT;
                end else if (rd_next == NIL || steps_reg == SPARE_FULL)
                    state_next = ST_RESULT;
                else state_next = ST_WALK_RD;
            end
            ST_FREE_PREV_RD:  state_next = ST_FREE_PREV_CHK;
            ST_FREE_PREV_CHK: state_next = ST_FREE_NEXT_RD;
            ST_FREE_NEXT_RD:  state_next = ST_FREE_NEXT_CHK;
            ST_FREE_NEXT_CHK: state_next = ST_MERGE_NN_RD;
            ST_MERGE_NN_RD:   state_next = ST_MERGE_NN_CHK;
            ST_MERGE_NN_CHK:  state_next = ST_PUSH;
            ST_PUSH:          state_next = ST_RESULT;
            ST_RESULT:        state_next = ST_IDLE;
            default:          state_next = ST_IDLE;
        endcase
    end

    // merge bookkeeping registers
    logic [IW-1:0] keep_reg;      // survivor block after prev merge
    logic [15:0]   kstart_reg;
    logic [16:0]   ksize_reg;
    logic [IW-1:0] knext_reg;
    logic [IW-1:0] kprev_reg;
    logic          pend1_reg, pend2_reg;
    logic [IW-1:0] rel1_reg, rel2_reg;

    // memory control, outputs
    always_comb begin
        rd_addr = cur_reg;
        sp_rd_addr = spare_cnt_reg;
        bw_en = 1'b0; pw_en = 1'b0; nw_en = 1'b0; sw_en = 1'b0;
        bw_addr = cur_reg; pw_addr = cur_reg; nw_addr = cur_reg; sw_addr = clr_reg;
        bw_data = '0; pw_data = NIL; nw_data = NIL; sw_data = clr_reg + 1'b1;
        case (state_reg)
            ST_CLEAR: begin
                bw_en = 1'b1; pw_en = 1'b1; nw_en = 1'b1; sw_en = 1'b1;
                bw_addr = clr_reg; pw_addr = clr_reg; nw_addr = clr_reg;
                bw_data.used = 1'b0;
                bw_data.start = '0;
                bw_data.size = (clr_reg == '0) ? pool_reg : 17'd0;
            end
            ST_SPLIT_NEW: begin
                // new block nb gets the tail of cur
                bw_en = 1'b1; pw_en = 1'b1; nw_en = 1'b1;
                bw_addr = sp_rd; pw_addr = sp_rd; nw_addr = sp_rd;
                bw_data.used = 1'b0;
                bw_data.start = 16'(17'(rd_base.start) + need_reg);
                bw_data.size = rd_base.size - need_reg;
                pw_data = cur_reg;
                nw_data = rd_next;
            end
            ST_SPLIT_NEXT: begin
                nw_en = 1'b1; nw_addr = cur_reg; nw_data = nb_reg;
                pw_en = (aux_reg != NIL); pw_addr = aux_reg; pw_data = nb_reg;
                bw_en = 1'b1; bw_addr = cur_reg;
                bw_data.used = 1'b1; bw_data.start = rd_base.start;
                bw_data.size = need_reg;
            end
            ST_ALLOC_DONE: begin
                if (!split_reg) begin
                    // no split happened: rd data still holds cur
                    bw_en = 1'b1; bw_addr = cur_reg;
                    bw_data.used = 1'b1; bw_data.start = rd_base.start;
                    bw_data.size = rd_base.size;
                end
            end
            ST_WALK_CHK: begin
                if (walk_hit && op_reg == OP_FREE) begin
                    bw_en = 1'b1; bw_addr = cur_reg;
                    bw_data.used = 1'b0; bw_data.start = rd_base.start;
                    bw_data.size = rd_base.size;
                end
            end
            ST_FREE_PREV_RD: rd_addr = kprev_reg;
            ST_FREE_PREV_CHK: begin
                if (kprev_reg != NIL && !rd_base.used) begin
                    // absorb cur into prev
                    nw_en = 1'b1; nw_addr = kprev_reg; nw_data = knext_reg;
                    bw_en = 1'b1; bw_addr = kprev_reg;
                    bw_data.used = 1'b0; bw_data.start = rd_base.start;
                    bw_data.size = rd_base.size + ksize_reg;
                    pw_en = (knext_reg != NIL); pw_addr = knext_reg; pw_data = kprev_reg;
                end
            end
            ST_FREE_NEXT_RD: rd_addr = knext_reg;
            ST_FREE_NEXT_CHK: rd_addr = knext_reg;
            ST_MERGE_NN_RD: rd_addr = knext_reg;
            ST_MERGE_NN_CHK: begin
                if (knext_reg != NIL && !rd_base.used) begin
                    nw_en = 1'b1; nw_addr = keep_reg; nw_data = rd_next;
                    bw_en = 1'b1; bw_addr = keep_reg;
                    bw_data.used = 1'b0;
                    bw_data.start = kstart_reg;
                    bw_data.size = ksize_reg + rd_base.size;
                    pw_en = (rd_next != NIL); pw_addr = rd_next; pw_data = keep_reg;
                end
            end
            ST_PUSH: begin
                sw_en = pend1_reg && (spare_cnt_reg < SPARE_FULL);
                sw_addr = spare_cnt_reg; sw_data = rel1_reg;
            end
            ST_RESULT: begin
                sw_en = pend2_reg && (spare_cnt_reg < SPARE_FULL);
                sw_addr = spare_cnt_reg; sw_data = rel2_reg;
            end
            default: ;
        endcase
    end

    function automatic logic [IW-1:0] nof_k(input logic [IW-1:0] n);
        return (n != NIL) ? n : '0;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            pool_reg <= PMAX;
            minb_reg <= 17'(MIN_FLOOR);
            clr_reg <= '0;
            mv_reg <= 1'b0;
            spare_cnt_reg <= SPARE_FULL;
            rov_reg <= '0;
            inuse_reg <= '0;
            pend1_reg <= 1'b0;
            pend2_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tready && state_reg != ST_RESULT) mv_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    spare_cnt_reg <= SPARE_FULL;
                    rov_reg <= '0;
                    inuse_reg <= '0;
                end
                ST_IDLE: begin
                    clr_reg <= '0;
                    pend1_reg <= 1'b0;
                    pend2_reg <= 1'b0;
                    if (cfg_fire) begin
                        if (cfg_index == REG_POOL)
                            pool_reg <= (cfg_data > PMAX) ? PMAX : cfg_data;
                        else
                            minb_reg <= (cfg_data < 17'(MIN_FLOOR)) ?
                                17'(MIN_FLOOR) : cfg_data;
                    end else if (s_fire) begin
                        op_reg <= in_op;
                        addr_reg <= in_addr;
                        need_reg <= (in_need < 18'(minb_reg)) ? minb_reg : in_need[16:0];
                        steps_reg <= '0;
                        val_reg <= '0;
                        aux_reg <= NIL;
                        split_reg <= 1'b0;
                        if (in_op == OP_ALLOC) begin
                            cur_reg <= rov_reg;
                            fail_reg <= (inuse_reg == pool_reg) || in_need[17];
                        end else begin
                            cur_reg <= '0;
                            fail_reg <= (in_op != OP_FIND) && (17'(in_addr) < HDR);
                        end
                    end
                end
                ST_ALLOC_CHK: begin
                    if (!fail_reg) begin
                        if (!rd_base.used && rd_base.size >= need_reg) begin
                            if (need_reg < rd_base.size && spare_cnt_reg != '0) begin
                                spare_cnt_reg <= spare_cnt_reg - 1'b1;
                                aux_reg <= rd_next;
                                split_reg <= 1'b1;
                            end
                        end else begin
                            cur_reg <= nof;
                            steps_reg <= steps_reg + 1'b1;
                            if (nof == rov_reg || steps_reg == SPARE_FULL)
                                fail_reg <= 1'b1;
                        end
                    end
                end
                ST_SPLIT_NEW: nb_reg <= sp_rd;
                ST_SPLIT_NEXT: begin
                    inuse_reg <= inuse_reg + need_reg;
                    rov_reg <= nb_reg;
                    val_reg <= 17'(rd_base.start) + HDR;
                end
                ST_ALLOC_DONE: begin
                    if (!split_reg) begin
                        inuse_reg <= inuse_reg + rd_base.size;
                        rov_reg <= nof;
                        val_reg <= 17'(rd_base.start) + HDR;
                    end
                end
                ST_WALK_CHK: begin
                    if (walk_hit) begin
                        val_reg <= (op_reg == OP_FIND) ? 17'(rd_base.start) + HDR :
                            (op_reg == OP_SIZE) ?
                            ((rd_base.size >= HDR) ? rd_base.size - HDR : 17'd0) : 17'd0;
                        keep_reg <= cur_reg;
                        kstart_reg <= rd_base.start;
                        ksize_reg <= rd_base.size;
                        fsize_reg <= rd_base.size;
                        kprev_reg <= rd_prev;
                        knext_reg <= rd_next;
                    end else begin
                        cur_reg <= rd_next;
                        steps_reg <= steps_reg + 1'b1;
                        if (rd_next == NIL || steps_reg == SPARE_FULL) fail_reg <= 1'b1;
                    end
                end
                ST_FREE_PREV_CHK: begin
                    if (kprev_reg != NIL && !rd_base.used) begin
                        if (rov_reg == keep_reg) rov_reg <= nof_k(knext_reg);
                        pend1_reg <= 1'b1;
                        rel1_reg <= keep_reg;
                        keep_reg <= kprev_reg;
                        kstart_reg <= rd_base.start;
                        ksize_reg <= rd_base.size + ksize_reg;
                    end
                end
                ST_MERGE_NN_CHK: begin
                    if (knext_reg != NIL && !rd_base.used) begin
                        if (rov_reg == knext_reg) rov_reg <= (rd_next != NIL) ? rd_next : '0;
                        pend2_reg <= 1'b1;
                        rel2_reg <= knext_reg;
                    end
                end
                ST_PUSH: begin
                    if (sw_en) spare_cnt_reg <= spare_cnt_reg + 1'b1;
                end
                ST_RESULT: begin
                    mv_reg <= 1'b1;
                    md_reg <= {6'd0, fail_reg ? 17'd0 : val_reg, fail_reg};
                    if (op_reg == OP_FREE && !fail_reg)
                        inuse_reg <= (inuse_reg >= fsize_reg) ? inuse_reg - fsize_reg : '0;
                    if (sw_en) spare_cnt_reg <= spare_cnt_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== verif/tb.sv =====
module tb
    import nfba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = 2049;
    localparam int HB = 8;
    localparam int PMAX = 65536;
    localparam int LIMIT = 20000000;

    typedef struct packed {
        logic        status;
        logic [16:0] value;
    } alloc_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    // allocator image kept alongside the block
    int unsigned blk_start [NB];
    int unsigned blk_size [NB];
    int unsigned blk_prev [NB];
    int unsigned blk_next [NB];
    bit          blk_used [NB];
    int unsigned free_stack [NB];
    int unsigned free_depth, rover, used_bytes, pool_len, min_len;

    alloc_result_t expected_results[$];
    logic [15:0]   live_handles[$];
    int            send_idle_pct, recv_idle_pct;
    int            hold_len;
    int            fail_count;
    int            cycle_count;

    next_fit_block_allocator_top dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("** next_fit_block_allocator_top: FAILED **");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready value
    always @(posedge aclk) begin
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[17:1] !== want.value) begin
                    $error("value expected %0d actual %0d", want.value, m_tdata[17:1]);
                    fail_count++;
                end
            end
        end
        if (hold_len > 0) begin
            hold_len <= hold_len - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void pool_init();
        for (int i = 0; i < NB; i++) begin
            blk_start[i] = 0;
            blk_size[i] = 0;
            blk_used[i] = 0;
            blk_prev[i] = NB;
            blk_next[i] = NB;
            free_stack[i] = i + 1;
        end
        blk_size[0] = pool_len;
        free_depth = NB - 1;
        rover = 0;
        used_bytes = 0;
        live_handles.delete();
    endfunction

    function automatic int unsigned next_wrap(int unsigned b);
        return (blk_next[b] < NB) ? blk_next[b] : 0;
    endfunction

    function automatic int unsigned absorb_into_prev(int unsigned h);
        int unsigned p, n;
        p = blk_prev[h];
        n = blk_next[h];
        blk_next[p] = n;
        blk_size[p] += blk_size[h];
        if (n < NB) blk_prev[n] = p;
        if (rover == h) rover = (n < NB) ? n : 0;
        if (free_depth < NB - 1) begin
            free_stack[free_depth] = h;
            free_depth++;
        end
        return p;
    endfunction

    function automatic void split_at(int unsigned b, int unsigned sz);
        int unsigned nb, n;
        if (sz >= blk_size[b] || free_depth == 0) return;
        free_depth--;
        nb = free_stack[free_depth];
        if (nb >= NB || nb == 0) return;
        n = blk_next[b];
        blk_prev[nb] = b;
        blk_next[nb] = n;
        blk_start[nb] = blk_start[b] + sz;
        blk_size[nb] = blk_size[b] - sz;
        blk_used[nb] = blk_used[b];
        if (n < NB) blk_prev[n] = nb;
        blk_next[b] = nb;
        blk_size[b] = sz;
    endfunction

    function automatic int unsigned block_of_handle(int unsigned addr);
        int unsigned b;
        b = 0;
        if (addr < HB) return NB;
        for (int s = 0; s < NB && b < NB; s++) begin
            if (blk_used[b] && blk_start[b] == addr - HB) return b;
            b = blk_next[b];
        end
        return NB;
    endfunction

    function automatic alloc_result_t predict_request(op_t op, int unsigned amount,
                                                      int unsigned addr);
        alloc_result_t r;
        int unsigned   b, sz, n;
        r.status = 1'b1;
        r.value = '0;
        case (op)
            OP_ALLOC: begin
                if (used_bytes != pool_len) begin
                    sz = amount + HB;
                    if (sz < min_len) sz = min_len;
                    b = rover;
                    for (int s = 0; s < NB; s++) begin
                        if (!blk_used[b] && blk_size[b] >= sz) begin
                            split_at(b, sz);
                            blk_used[b] = 1;
                            used_bytes += blk_size[b];
                            rover = next_wrap(b);
                            r.status = 1'b0;
                            r.value = 17'(blk_start[b] + HB);
                            live_handles.push_back(16'(blk_start[b] + HB));
                            break;
                        end
                        b = next_wrap(b);
                        if (b == rover) break;
                    end
                end
            end
            OP_FREE: begin
                b = block_of_handle(addr);
                if (b < NB) begin
                    blk_used[b] = 0;
                    sz = blk_size[b];
                    if (blk_prev[b] < NB && !blk_used[blk_prev[b]]) b = absorb_into_prev(b);
                    n = blk_next[b];
                    if (n < NB && !blk_used[n]) void'(absorb_into_prev(n));
                    used_bytes = (used_bytes >= sz) ? used_bytes - sz : 0;
                    r.status = 1'b0;
                    foreach (live_handles[i]) begin
                        if (live_handles[i] == addr) begin
                            live_handles.delete(i);
                            break;
                        end
                    end
                end
            end
            OP_FIND: begin
                b = 0;
                for (int s = 0; s < NB && b < NB; s++) begin
                    if (blk_used[b] && blk_start[b] <= addr
                        && addr < blk_start[b] + blk_size[b]) begin
                        r.status = 1'b0;
                        r.value = 17'(blk_start[b] + HB);
                        break;
                    end
                    b = blk_next[b];
                end
            end
            default: begin
                b = block_of_handle(addr);
                if (b < NB) begin
                    r.status = 1'b0;
                    r.value = (blk_size[b] >= HB) ? 17'(blk_size[b] - HB) : 17'd0;
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_req(op_t op, logic [16:0] amount, logic [15:0] addr);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, addr, amount, op};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_request(op, amount, addr));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [16:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_POOL) pool_len = (data > PMAX) ? PMAX : data;
        else min_len = (data < MIN_FLOOR) ? MIN_FLOOR : data;
        pool_init();
    endtask

    task automatic send_random_item();
        int unsigned pick, amt, adr;
        pick = $urandom_range(99);
        case ($urandom_range(9))
            0:       amt = $urandom_range(131071);
            1, 2:    amt = $urandom_range(pool_len / 4);
            default: amt = $urandom_range(pool_len / 16);
        endcase
        if ($urandom_range(4) == 0 || pool_len == 0) adr = $urandom_range(65535);
        else adr = $urandom_range(pool_len - 1);
        if (pick >= 40 && pick < 90 && live_handles.size() != 0 && $urandom_range(9) != 0)
            adr = live_handles[$urandom_range(live_handles.size() - 1)];
        if (pick < 40) send_req(OP_ALLOC, 17'(amt), 16'(adr));
        else if (pick < 70) send_req(OP_FREE, 17'(amt), 16'(adr));
        else if (pick < 85) send_req(OP_SIZE, 17'(amt), 16'(adr));
        else send_req(OP_FIND, 17'(amt), 16'(adr));
    endtask

    task automatic test_basic_ops();
        send_req(OP_ALLOC, 17'd0, 16'd0);
        send_req(OP_ALLOC, 17'd65536, 16'hffff);
        send_req(OP_ALLOC, 17'h1ffff, 16'd0);
        send_req(OP_ALLOC, 17'd100, 16'd0);
        send_req(OP_FIND, 17'd0, 16'd0);
        send_req(OP_FIND, 17'd0, 16'd50);
        send_req(OP_FIND, 17'd0, 16'hffff);
        send_req(OP_SIZE, 17'd0, 16'd8);
        send_req(OP_SIZE, 17'd0, 16'd48);
        send_req(OP_SIZE, 17'd0, 16'd7);
        send_req(OP_SIZE, 17'd0, 16'hffff);
        send_req(OP_FREE, 17'd0, 16'd3);
        send_req(OP_FREE, 17'd0, 16'd8);
        send_req(OP_FREE, 17'd0, 16'd8);
        send_req(OP_FREE, 17'd0, 16'hffff);
        send_req(OP_FREE, 17'd0, 16'd48);
        send_req(OP_ALLOC, 17'd65528, 16'd0);
        send_req(OP_ALLOC, 17'd0, 16'd0);
    endtask

    task automatic test_full_pool();
        write_reg(REG_POOL, 17'd64);
        send_req(OP_ALLOC, 17'd24, 16'd0);
        send_req(OP_ALLOC, 17'd0, 16'd0);
        send_req(OP_ALLOC, 17'd0, 16'd0);
        send_req(OP_FIND, 17'd0, 16'd40);
        send_req(OP_FREE, 17'd0, 16'd8);
        send_req(OP_FREE, 17'd0, 16'd40);
        send_req(OP_ALLOC, 17'd56, 16'd0);
        send_req(OP_SIZE, 17'd0, 16'd8);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_POOL, 17'd0);
        send_req(OP_ALLOC, 17'd0, 16'd0);
        send_req(OP_FIND, 17'd0, 16'd0);
        write_reg(REG_POOL, 17'h1ffff);
        send_req(OP_ALLOC, 17'd65528, 16'd0);
        write_reg(REG_MIN, 17'd0);
        send_req(OP_ALLOC, 17'd0, 16'd0);
        send_req(OP_SIZE, 17'd0, 16'd8);
        write_reg(REG_MIN, 17'd65536);
        send_req(OP_ALLOC, 17'd0, 16'd0);
        send_req(OP_ALLOC, 17'd0, 16'd0);
        write_reg(REG_MIN, 17'h1ffff);
        send_req(OP_ALLOC, 17'd0, 16'd0);
        write_reg(REG_MIN, 17'd32);
    endtask

    // three 40-byte blocks, then 32-byte blocks until one descriptor is left
    task automatic test_descriptor_exhaustion();
        write_reg(REG_POOL, 17'd65536);
        repeat (3) send_req(OP_ALLOC, 17'd32, 16'd0);
        repeat (2044) send_req(OP_ALLOC, 17'd0, 16'd0);
        send_req(OP_FREE, 17'd0, 16'd8);
        send_req(OP_ALLOC, 17'd0, 16'd0);
        send_req(OP_FREE, 17'd0, 16'd88);
        send_req(OP_ALLOC, 17'd0, 16'd0);
        send_req(OP_SIZE, 17'd0, 16'd88);
        send_req(OP_FIND, 17'd0, 16'd36);
    endtask

    task automatic test_backpressure();
        write_reg(REG_POOL, 17'd2048);
        hold_len = 600;
        repeat (40) send_random_item();
        wait_drained();
        repeat (20) send_random_item();
    endtask

    task automatic test_random(int n, int pool, int min_b, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        write_reg(REG_POOL, 17'(pool));
        write_reg(REG_MIN, 17'(min_b));
        repeat (n) send_random_item();
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        hold_len = 0;
        send_idle_pct = 13;
        recv_idle_pct = 65;
        pool_len = PMAX;
        min_len = MIN_FLOOR;
        pool_init();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_basic_ops();
        test_full_pool();
        test_register_extremes();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_descriptor_exhaustion();
        send_idle_pct = 13;
        recv_idle_pct = 65;
        test_backpressure();
        test_random(120, 4096, 32, 13, 65);
        test_random(120, 1024, 48, 65, 13);
        test_random(120, 65536, 32, 0, 0);
        wait_drained();
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** next_fit_block_allocator_top: PASSED **");
        end else begin
            $display("** next_fit_block_allocator_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/nfba_pkg.sv
rtl/next_fit_block_allocator_top.sv
verif/tb.sv
